// File: design/udpx_pkg.sv
`default_nettype none
package udpx_pkg;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] UDP_HDR_BYTES  = 16'd8;
	localparam logic [15:0] ETH_HDR_BYTES  = 16'd14;
	localparam logic [15:0] OFF_ETHERTYPE  = 16'd13;
	localparam logic [15:0] OFF_IP_PROTO   = 16'd23;
	localparam logic [15:0] OFF_MAX        = 16'hFFFF;

	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_MATCH_PORT  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD = CFG_IDX_W'(1);

	localparam logic [15:0] MATCH_PORT_RST  = 16'd0;
	localparam logic [15:0] MAX_PAYLOAD_RST = 16'd1472;

	// front-to-back queue
	localparam int QDEPTH = 2;
	localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		PH_HEADER,
		PH_PAYLOAD,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [15:0] length;
		logic [63:0] stamp;
		logic        first;
		logic        last;
		logic        truncated;
	} q_entry_t;

	typedef struct packed {
		logic full;
		logic valid;
	} q_status_t;

endpackage
`default_nettype wire

// File: design/udpx_front.sv
`default_nettype none
module udpx_front (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      frame_byte,
	input  wire logic                            frame_end,
	input  wire logic [63:0]                     arrival_time,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [udpx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [15:0]                     cfg_data,
	input  wire udpx_pkg::q_status_t             q_status,
	output logic                                 push,
	output udpx_pkg::q_entry_t                   push_entry
);
	import udpx_pkg::*;

	logic [15:0] match_port_q, max_payload_q;
	phase_t      phase_q, phase_d;
	logic [15:0] offset_q, offset_d;
	logic [3:0]  ihl_q, ihl_d;
	logic [15:0] shift_q, shift_d;
	logic [15:0] decl_q, decl_d;
	logic [15:0] left_q, left_d;
	logic [63:0] time_q, time_d;

	logic        accept;
	logic [15:0] shift_nx;
	logic [15:0] udp_start;
	logic [15:0] plen;
	logic [15:0] left_dec;

	assign cfg_ready = 1'b1;
	assign in_stall  = q_status.full;
	assign accept    = in_valid && !in_stall;

	assign shift_nx  = {shift_q[7:0], frame_byte};
	assign udp_start = ETH_HDR_BYTES + {10'd0, ihl_q, 2'b00};
	assign plen      = shift_nx - UDP_HDR_BYTES;
	assign left_dec  = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_port_q  <= MATCH_PORT_RST;
			max_payload_q <= MAX_PAYLOAD_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_MATCH_PORT:  match_port_q  <= cfg_data;
				REG_MAX_PAYLOAD: max_payload_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state of the header parser
	always_comb begin
		phase_d  = phase_q;
		offset_d = offset_q;
		ihl_d    = ihl_q;
		shift_d  = shift_q;
		decl_d   = decl_q;
		left_d   = left_q;
		time_d   = time_q;
		case (phase_q)
			PH_HEADER: begin
				if (offset_q == 16'd0)
					time_d = arrival_time;
				shift_d = shift_nx;
				if (offset_q == OFF_ETHERTYPE) begin
					if (shift_nx != ETHERTYPE_IPV4)
						phase_d = PH_SKIP;
				end else if (offset_q == ETH_HDR_BYTES) begin
					ihl_d = frame_byte[3:0];
					if (frame_byte[3:0] < 4'd5)
						phase_d = PH_SKIP;
				end else if (offset_q == OFF_IP_PROTO) begin
					if (frame_byte != PROTO_UDP)
						phase_d = PH_SKIP;
				end else if (offset_q > OFF_IP_PROTO) begin
					if (offset_q == udp_start + 16'd3) begin
						if (shift_nx != match_port_q)
							phase_d = PH_SKIP;
					end else if (offset_q == udp_start + 16'd5) begin
						if (plen == 16'd0 || plen > max_payload_q) begin
							phase_d = PH_SKIP;
						end else begin
							decl_d = plen;
							left_d = plen;
						end
					end else if (offset_q == udp_start + UDP_HDR_BYTES - 16'd1) begin
						phase_d = PH_PAYLOAD;
					end
				end
				if (offset_q != OFF_MAX)
					offset_d = offset_q + 16'd1;
			end
			PH_PAYLOAD: begin
				left_d = left_dec;
				if (left_dec == 16'd0)
					phase_d = PH_SKIP;
			end
			default: ;
		endcase
		if (frame_end) begin
			offset_d = 16'd0;
			phase_d  = PH_HEADER;
			shift_d  = 16'd0;
		end
	end

	// payload byte classification
	always_comb begin
		push                 = accept && (phase_q == PH_PAYLOAD);
		push_entry.data      = frame_byte;
		push_entry.length    = decl_q;
		push_entry.stamp     = time_q;
		push_entry.first     = (left_q == decl_q);
		push_entry.last      = (left_dec == 16'd0) || frame_end;
		push_entry.truncated = frame_end && (left_dec != 16'd0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			offset_q <= 16'd0;
			ihl_q    <= 4'd0;
			shift_q  <= 16'd0;
			decl_q   <= 16'd0;
			left_q   <= 16'd0;
			time_q   <= 64'd0;
		end else if (accept) begin
			phase_q  <= phase_d;
			offset_q <= offset_d;
			ihl_q    <= ihl_d;
			shift_q  <= shift_d;
			decl_q   <= decl_d;
			left_q   <= left_d;
			time_q   <= time_d;
		end
	end

endmodule
`default_nettype wire

// File: design/udpx_queue.sv
`default_nettype none
module udpx_queue (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire udpx_pkg::q_entry_t  push_entry,
	input  wire logic                pop,
	output udpx_pkg::q_entry_t       head,
	output udpx_pkg::q_status_t      status
);
	import udpx_pkg::*;

	q_entry_t            mem_q [QDEPTH];
	logic [QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0]   count_q;
	logic                do_pop;

	assign status.full  = (count_q == QCNT_W'(QDEPTH));
	assign status.valid = (count_q != '0);
	assign head         = mem_q[rd_ptr_q];
	assign do_pop       = pop && status.valid;

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			if (do_pop)
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			case ({push, do_pop})
				2'b10:   count_q <= count_q + QCNT_W'(1);
				2'b01:   count_q <= count_q - QCNT_W'(1);
				default: ;
			endcase
		end
	end

endmodule
`default_nettype wire

// File: design/udpx_back.sv
`default_nettype none
module udpx_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire udpx_pkg::q_entry_t  head,
	input  wire udpx_pkg::q_status_t q_status,
	output logic                     pop,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output logic [7:0]               payload_byte,
	output logic [15:0]              payload_length,
	output logic [63:0]              stamp,
	output logic                     last_of_payload,
	output logic                     truncated,
	output logic [31:0]              accepted_total
);
	import udpx_pkg::*;

	logic        valid_q;
	logic [31:0] count_q;
	logic [31:0] count_nx;
	logic [7:0]  byte_q;
	logic [15:0] len_q;
	logic [63:0] stamp_q;
	logic        last_q, trunc_q;
	logic [31:0] total_q;

	// output register free or being drained this cycle
	assign pop      = q_status.valid && (!valid_q || !out_stall);
	assign count_nx = head.first ? count_q + 32'd1 : count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			count_q <= 32'd0;
		end else begin
			if (pop) begin
				valid_q <= 1'b1;
				count_q <= count_nx;
			end else if (!out_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			byte_q  <= head.data;
			len_q   <= head.length;
			stamp_q <= head.stamp;
			last_q  <= head.last;
			trunc_q <= head.truncated;
			total_q <= count_nx;
		end
	end

	assign out_valid       = valid_q;
	assign payload_byte    = byte_q;
	assign payload_length  = len_q;
	assign stamp           = stamp_q;
	assign last_of_payload = last_q;
	assign truncated       = trunc_q;
	assign accepted_total  = total_q;

endmodule
`default_nettype wire

// File: design/udp_port_payload_extractor.sv
// UDP port payload extractor.
// Input channel (in_valid / in_stall): one Ethernet frame byte per transaction,
// frame_end on the last byte, arrival_time sampled on the first byte.
// Frames with EtherType IPv4, IP protocol UDP, the configured destination port
// and a payload length in 1..max_payload have their payload bytes emitted on
// the output channel (out_valid / out_stall), one byte per transaction, with
// length, timestamp, last/truncated flags and the running accepted count.
// Config channel (cfg_valid / cfg_ready, always ready): index 0 match_port,
// index 1 max_payload; write only while idle.
// Throughput: one byte per cycle while neither side stalls. A payload byte
// passes through the queue write, then the output register.
// A two-entry queue sits between the header parser and the output register;
// in_stall is raised only while that queue is full, so a stalled receiver
// backs up into the input once the queue holds two bytes. Header and
// padding bytes are consumed without output.
// Reset: parser at the frame start, counters zero, match_port 0,
// max_payload 1472, output and queue empty.
`default_nettype none
module udp_port_payload_extractor (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [7:0]                      frame_byte,
	input  wire logic                            frame_end,
	input  wire logic [63:0]                     arrival_time,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [7:0]                           payload_byte,
	output logic [15:0]                          payload_length,
	output logic [63:0]                          stamp,
	output logic                                 last_of_payload,
	output logic                                 truncated,
	output logic [31:0]                          accepted_total,
	input  wire logic                            cfg_valid,
	output logic                                 cfg_ready,
	input  wire logic [udpx_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [15:0]                     cfg_data
);
	import udpx_pkg::*;

	q_status_t q_status;
	q_entry_t  push_entry, head;
	logic      push, pop;

	udpx_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.frame_byte   (frame_byte),
		.frame_end    (frame_end),
		.arrival_time (arrival_time),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.q_status     (q_status),
		.push         (push),
		.push_entry   (push_entry)
	);

	udpx_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.status     (q_status)
	);

	udpx_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.head            (head),
		.q_status        (q_status),
		.pop             (pop),
		.out_valid       (out_valid),
		.out_stall       (out_stall),
		.payload_byte    (payload_byte),
		.payload_length  (payload_length),
		.stamp           (stamp),
		.last_of_payload (last_of_payload),
		.truncated       (truncated),
		.accepted_total  (accepted_total)
	);

endmodule
`default_nettype wire

// File: tb/tb_udp_port_payload_extractor.sv
`timescale 1ns / 1ps
module tb_udp_port_payload_extractor;
	import udpx_pkg::*;

	typedef struct packed {
		logic [7:0]  pbyte;
		logic [15:0] plen;
		logic [63:0] pstamp;
		logic        plast;
		logic        ptrunc;
		logic [31:0] ptotal;
	} payload_beat_t;

	class extract_scoreboard;
		logic [15:0] port_cfg;
		logic [15:0] max_cfg;
		logic [15:0] offset;
		phase_t      phase;
		logic [3:0]  ihl;
		logic [15:0] shift;
		logic [15:0] declared;
		logic [15:0] left;
		logic [63:0] t_latch;
		logic [31:0] accepted;
		payload_beat_t expected_q[$];
		int mismatches;

		function new();
			port_cfg = MATCH_PORT_RST;
			max_cfg = MAX_PAYLOAD_RST;
			offset = '0;
			phase = PH_HEADER;
			ihl = '0;
			shift = '0;
			declared = '0;
			left = '0;
			t_latch = '0;
			accepted = '0;
			mismatches = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
			if (idx == REG_MATCH_PORT)
				port_cfg = val;
			else if (idx == REG_MAX_PAYLOAD)
				max_cfg = val;
		endfunction

		// header parse for one byte; mirrors the offset-driven field checks
		function void parse_header(logic [7:0] b, logic [63:0] t);
			int off;
			int udp_start;
			logic [15:0] plen;
			off = int'(offset);
			if (off == 0)
				t_latch = t;
			shift = {shift[7:0], b};
			if (off == int'(OFF_ETHERTYPE)) begin
				if (shift != ETHERTYPE_IPV4)
					phase = PH_SKIP;
			end else if (off == int'(ETH_HDR_BYTES)) begin
				ihl = b[3:0];
				if (ihl < 4'd5)
					phase = PH_SKIP;
			end else if (off == int'(OFF_IP_PROTO)) begin
				if (b != PROTO_UDP)
					phase = PH_SKIP;
			end else if (off > int'(OFF_IP_PROTO)) begin
				udp_start = int'(ETH_HDR_BYTES) + 4 * int'(ihl);
				if (off == udp_start + 3) begin
					if (shift != port_cfg)
						phase = PH_SKIP;
				end else if (off == udp_start + 5) begin
					plen = shift - UDP_HDR_BYTES;
					if (plen == 16'd0 || plen > max_cfg) begin
						phase = PH_SKIP;
					end else begin
						declared = plen;
						left = plen;
					end
				end else if (off == udp_start + int'(UDP_HDR_BYTES) - 1) begin
					phase = PH_PAYLOAD;
				end
			end
			if (offset != OFF_MAX)
				offset++;
		endfunction

		function void note_input(logic [7:0] b, logic e, logic [63:0] t);
			payload_beat_t beat;
			if (phase == PH_HEADER) begin
				parse_header(b, t);
			end else if (phase == PH_PAYLOAD) begin
				// count on the first payload byte only
				if (left == declared)
					accepted++;
				if (left != 16'd0)
					left--;
				beat.pbyte = b;
				beat.plen = declared;
				beat.pstamp = t_latch;
				beat.plast = (left == 16'd0) || e;
				beat.ptrunc = e && (left != 16'd0);
				beat.ptotal = accepted;
				expected_q.push_back(beat);
				if (left == 16'd0)
					phase = PH_SKIP;
			end
			if (e) begin
				offset = '0;
				phase = PH_HEADER;
				shift = '0;
			end
		endfunction

		function void check_result(payload_beat_t got);
			payload_beat_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("ERROR %0t: unexpected payload transaction byte=%h len=%0d",
						$realtime, got.pbyte, got.plen);
				return;
			end
			want = expected_q.pop_front();
			if (got.pbyte !== want.pbyte || got.plen !== want.plen ||
				got.pstamp !== want.pstamp || got.plast !== want.plast ||
				got.ptrunc !== want.ptrunc || got.ptotal !== want.ptotal) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("ERROR %0t: payload transaction mismatch", $realtime);
					$display("  exp byte=%h len=%0d stamp=%h last=%b trunc=%b total=%0d",
						want.pbyte, want.plen, want.pstamp, want.plast, want.ptrunc,
						want.ptotal);
					$display("  got byte=%h len=%0d stamp=%h last=%b trunc=%b total=%0d",
						got.pbyte, got.plen, got.pstamp, got.plast, got.ptrunc,
						got.ptotal);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [7:0] frame_byte = '0;
	logic frame_end = 1'b0;
	logic [63:0] arrival_time = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] payload_byte;
	logic [15:0] payload_length;
	logic [63:0] stamp;
	logic last_of_payload;
	logic truncated;
	logic [31:0] accepted_total;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	extract_scoreboard sb = new();
	logic quiet = 1'b0;
	int bytes_sent = 0;

	always #5 clk = ~clk;

	udp_port_payload_extractor DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.frame_byte(frame_byte),
		.frame_end(frame_end),
		.arrival_time(arrival_time),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.payload_byte(payload_byte),
		.payload_length(payload_length),
		.stamp(stamp),
		.last_of_payload(last_of_payload),
		.truncated(truncated),
		.accepted_total(accepted_total),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	function automatic logic [63:0] rnd64();
		return {$urandom, $urandom};
	endfunction

	task automatic send_byte(logic [7:0] b, logic e, logic [63:0] t);
		if (!quiet && $urandom_range(0, 9) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
		frame_byte <= b;
		frame_end <= e;
		arrival_time <= t;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		sb.note_input(b, e, t);
		bytes_sent++;
	endtask

	// Ethernet + IPv4 (ihl words, at least 5 laid out) + UDP header, payload, padding.
	// cut > 0 ends the frame after that many bytes.
	task automatic send_frame(logic [15:0] et, logic [3:0] ihl, logic [7:0] proto,
		logic [15:0] dport, logic [15:0] ulen, int n, int pad, int cut, logic [63:0] t0);
		logic [7:0] fb[$];
		int words;
		fb = {};
		for (int i = 0; i < 12; i++)
			fb.push_back(8'($urandom));
		fb.push_back(et[15:8]);
		fb.push_back(et[7:0]);
		words = (ihl < 4'd5) ? 5 : int'(ihl);
		fb.push_back({4'($urandom), ihl});
		for (int i = 1; i < 4 * words; i++)
			fb.push_back((i == 9) ? proto : 8'($urandom));
		fb.push_back(8'($urandom));
		fb.push_back(8'($urandom));
		fb.push_back(dport[15:8]);
		fb.push_back(dport[7:0]);
		fb.push_back(ulen[15:8]);
		fb.push_back(ulen[7:0]);
		fb.push_back(8'($urandom));
		fb.push_back(8'($urandom));
		for (int i = 0; i < n + pad; i++)
			fb.push_back(8'($urandom));
		if (cut > 0 && cut < fb.size())
			fb = fb[0:cut-1];
		foreach (fb[k])
			send_byte(fb[k], k == fb.size() - 1, (k == 0) ? t0 : rnd64());
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg_index <= idx;
		cfg_data <= val;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		sb.write_reg(idx, val);
	endtask

	// drain all outstanding payload transactions, then let the pipeline settle
	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic random_traffic(int target);
		int start;
		int kind;
		int cap;
		int n;
		int pad;
		int cut;
		logic [15:0] et;
		logic [3:0] ihl;
		logic [7:0] proto;
		logic [15:0] dport;
		logic [15:0] ulen;
		start = bytes_sent;
		while (bytes_sent - start < target) begin
			kind = $urandom_range(0, 99);
			cap = (sb.max_cfg < 16'd24) ? int'(sb.max_cfg) : 24;
			n = $urandom_range(1, cap);
			et = ETHERTYPE_IPV4;
			ihl = 4'($urandom_range(5, 15));
			proto = PROTO_UDP;
			dport = sb.port_cfg;
			ulen = 16'(n) + UDP_HDR_BYTES;
			pad = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
			cut = 0;
			if (kind < 8)
				cut = 14 + 4 * int'(ihl) + 8 + $urandom_range(1, n);
			else if (kind < 13)
				et = 16'($urandom);
			else if (kind < 18)
				ihl = 4'($urandom_range(0, 4));
			else if (kind < 23)
				proto = 8'($urandom);
			else if (kind < 28)
				dport = 16'($urandom);
			else if (kind < 31)
				ulen = 16'($urandom);
			else if (kind < 34)
				ulen = 16'($urandom_range(0, 8));
			else if (kind < 39)
				cut = $urandom_range(1, 60);
			send_frame(et, ihl, proto, dport, ulen, n, pad, cut, rnd64());
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset config: port 0, max 1472
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd0, 16'd9, 1, 0, 0, '1);
		send_frame(ETHERTYPE_IPV4, 4'd15, PROTO_UDP, 16'd0, 16'd13, 5, 4, 0, '0);
		send_frame(16'h86DD, 4'd5, PROTO_UDP, 16'd0, 16'd12, 4, 0, 0, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd4, PROTO_UDP, 16'd0, 16'd12, 4, 0, 0, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd0, PROTO_UDP, 16'd0, 16'd12, 4, 0, 0, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd5, 8'd6, 16'd0, 16'd12, 4, 0, 0, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'hFFFF, 16'd12, 4, 0, 0, rnd64());
		// UDP length below the header size wraps; length of exactly 8 is empty
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd0, 16'd7, 2, 0, 0, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd0, 16'd8, 2, 0, 0, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd0, 16'd1481, 4, 0, 0, rnd64());
		// declared at max, frame ends early in the payload
		send_frame(ETHERTYPE_IPV4, 4'd6, PROTO_UDP, 16'd0, 16'd1480, 3, 0, 0, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd0, 16'd12, 4, 0, 30, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'd0, 16'd12, 4, 0, 1, rnd64());
		random_traffic(150);
		settle();

		write_reg(REG_MATCH_PORT, 16'hFFFF);
		write_reg(REG_MAX_PAYLOAD, 16'd1);
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'hFFFF, 16'd9, 1, 3, 0, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, 16'hFFFF, 16'd10, 2, 0, 0, rnd64());
		random_traffic(150);
		settle();

		write_reg(REG_MATCH_PORT, 16'($urandom));
		write_reg(REG_MAX_PAYLOAD, 16'd65527);
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, sb.port_cfg, 16'hFFFF, 6, 0, 0, rnd64());
		send_frame(ETHERTYPE_IPV4, 4'd5, PROTO_UDP, sb.port_cfg, 16'd0, 6, 0, 0, rnd64());
		random_traffic(150);
		settle();

		write_reg(REG_MATCH_PORT, 16'($urandom));
		write_reg(REG_MAX_PAYLOAD, 16'($urandom_range(1, 40)));
		random_traffic(150);
		settle();

		// tail with no idling on either side
		write_reg(REG_MATCH_PORT, 16'($urandom));
		write_reg(REG_MAX_PAYLOAD, MAX_PAYLOAD_RST);
		quiet = 1'b1;
		random_traffic(150);
		settle();

		if (sb.mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// output side: check accepted transactions, stall in random bursts
	initial begin
		int stall_left;
		payload_beat_t got;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && !out_stall) begin
				got.pbyte = payload_byte;
				got.plen = payload_length;
				got.pstamp = stamp;
				got.plast = last_of_payload;
				got.ptrunc = truncated;
				got.ptotal = accepted_total;
				sb.check_result(got);
			end
			if (stall_left > 0)
				stall_left--;
			else if (!quiet && $urandom_range(0, 7) == 0)
				stall_left = $urandom_range(1, 11);
			out_stall <= (stall_left > 0);
		end
	end

	initial begin
		#5_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule
